@@ rtl/sdss_pkg.sv @@
// ----------------------------------------------------------------------------
// sdss_pkg: shared types and constants
// request and frame word layouts, queue record, glyph table
// ----------------------------------------------------------------------------
package sdss_pkg;

  // request: value to show and decimal point position
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [3:0]  point_position;
  } sdss_req_t;

  // one frame word per display digit
  typedef struct packed {
    logic [2:0] digit_index;
    logic [7:0] segments;
    logic [7:0] digit_select;
    logic       last_digit;
  } sdss_word_t;

  // converted request handed from the front to the back
  typedef struct packed {
    logic [7:0][3:0] digits;     // low eight decimal digits
    logic [7:0]      nonzero;    // remaining magnitude nonzero at each digit
    logic            negative;
    logic [3:0]      pos;
  } sdss_job_t;

  typedef enum logic {
    FR_IDLE,
    FR_CONV
  } sdss_front_state_t;

  localparam logic [7:0] SEG_MINUS = 8'hBF;
  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_POINT = 8'h80;
  localparam logic [3:0] POS_FLOOR = 4'b1000;   // -8, the countdown stops here

  // lit segments a..g for a decimal digit
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/signed_decimal_to_seven_segment_frames.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_to_seven_segment_frames: signed value to display frame words
// converts a signed value and decimal point position into DIGITS words of
// active-low segments and one-hot digit select, least significant first
// ----------------------------------------------------------------------------
// usage
//   src channel: one request (value, point_position) per src_valid/src_stall
//   handshake; dst channel: DIGITS frame words per request, the last one
//   flagged by last_digit
//   first word: dst_valid rises with it after the bit-serial shift and add-3
//   conversion of the 32-bit magnitude, the queue and the sequencer registers
//   a new request is taken while idle or as the converter pushes the result of
//   the one before; word output runs in parallel
//   a two-entry queue sits between the converter and the word sequencer, so
//   a stalled receiver holds the current word in the output register while
//   conversions go on until the queue fills; the converter then holds its
//   finished result and src_stall stays high
//   reset: synchronous, clears the converter, queue and output valid
// ----------------------------------------------------------------------------
module signed_decimal_to_seven_segment_frames #(
  parameter int DIGITS = 8       // display width, 1 to 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  sdss_pkg::sdss_req_t  src_req,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output sdss_pkg::sdss_word_t dst_word
);
  import sdss_pkg::*;

  // converter to queue
  logic      push;
  logic      push_ready;
  sdss_job_t push_job;

  // queue to sequencer
  logic      head_valid;
  logic      pop;
  sdss_job_t head;

  // front: takes requests and converts the magnitude to decimal digits
  sdss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_req   (src_req),
    .q_push    (push),
    .q_ready   (push_ready),
    .q_job     (push_job)
  );

  // short queue decoupling conversion from word output
  sdss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .ready    (push_ready),
    .push_job (push_job),
    .valid    (head_valid),
    .pop      (pop),
    .head     (head)
  );

  // back: one frame word per cycle unless dst_stall holds it; point, minus and blanking applied here
  sdss_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_pop     (pop),
    .q_head    (head),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

endmodule

@@ rtl/sdss_front.sv @@
// ----------------------------------------------------------------------------
// sdss_front: request intake and binary to decimal conversion
// takes a request, converts the magnitude one bit per cycle (shift and add 3)
// ----------------------------------------------------------------------------
module sdss_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  sdss_pkg::sdss_req_t  src_req,
  output logic              q_push,
  input  logic              q_ready,
  output sdss_pkg::sdss_job_t  q_job
);
  import sdss_pkg::*;

  sdss_front_state_t state, state_next;
  logic [31:0]      bin;
  logic [9:0][3:0]  bcd;
  logic [4:0]       cnt;
  logic             negative;
  logic [3:0]       pos;

  logic [9:0][3:0]  bcd_adj;
  logic [9:0][3:0]  bcd_step;
  logic [9:0]       any_nz;
  logic             last_step;
  logic             accept;
  logic             advance;
  logic [31:0]      mag;

  assign mag = src_req.value[31] ? (32'd0 - 32'(src_req.value)) : 32'(src_req.value);

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      bcd_adj[k] = (bcd[k] >= 4'd5) ? 4'(bcd[k] + 4'd3) : bcd[k];
    end
    bcd_step = 40'({bcd_adj, bin[31]});
    any_nz[9] = (bcd_step[9] != 4'd0);
    for (int k = 8; k >= 0; k--) begin
      any_nz[k] = any_nz[k + 1] | (bcd_step[k] != 4'd0);
    end
  end

  assign last_step = (cnt == 5'd31);
  assign q_push    = (state == FR_CONV) && last_step && q_ready;
  assign src_stall = (state == FR_CONV) && !q_push;
  assign accept    = src_valid && !src_stall;
  assign advance   = (state == FR_CONV) && !(last_step && !q_ready);

  always_comb begin
    q_job.digits   = bcd_step[7:0];
    q_job.nonzero  = any_nz[7:0];
    q_job.negative = negative;
    q_job.pos      = pos;
  end

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (accept) state_next = FR_CONV;
      end
      FR_CONV: begin
        if (q_push) state_next = accept ? FR_CONV : FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin      <= mag;
      bcd      <= '0;
      cnt      <= 5'd0;
      negative <= src_req.value[31];
      pos      <= src_req.point_position;
    end else if (advance) begin
      bin <= bin << 1;
      bcd <= bcd_step;
      cnt <= 5'(cnt + 5'd1);
    end
  end

endmodule

@@ rtl/sdss_queue.sv @@
// ----------------------------------------------------------------------------
// sdss_queue: two-entry queue between conversion and frame output
// lets the converter run ahead while the frame output is stalled
// ----------------------------------------------------------------------------
module sdss_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              ready,
  input  sdss_pkg::sdss_job_t  push_job,
  output logic              valid,
  input  logic              pop,
  output sdss_pkg::sdss_job_t  head
);
  import sdss_pkg::*;

  sdss_job_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign ready   = (count != 2'd2);
  assign valid   = (count != 2'd0);
  assign head    = slots[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= 2'(count + 2'd1);
        2'b01:   count <= 2'(count - 2'd1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

endmodule

@@ rtl/sdss_back.sv @@
// ----------------------------------------------------------------------------
// sdss_back: frame word sequencer
// walks the digits of one converted request, one word per cycle while the
// receiver does not stall, into an output register
// ----------------------------------------------------------------------------
module sdss_back #(
  parameter int DIGITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  sdss_pkg::sdss_job_t  q_head,
  output logic              dst_valid,
  input  logic              dst_stall,
  output sdss_pkg::sdss_word_t dst_word
);
  import sdss_pkg::*;

  localparam logic [2:0] LAST = 3'(DIGITS - 1);

  logic            active;
  logic [7:0][3:0] digits;
  logic [7:0]      nonzero;
  logic            negative;
  logic [3:0]      pos;
  logic [2:0]      d;

  logic            load;
  logic            is_last;
  logic [7:0]      seg;
  logic            minus_used;

  assign load    = active && (!dst_valid || !dst_stall);
  assign is_last = (d == LAST);
  assign q_pop   = q_valid && (!active || (load && is_last));

  always_comb begin
    minus_used = 1'b0;
    if (nonzero[d] || !pos[3]) begin
      seg = ~(glyph(digits[d]) | ((pos == 4'd0) ? SEG_POINT : 8'h00));
    end else if (negative) begin
      seg        = SEG_MINUS;
      minus_used = 1'b1;
    end else begin
      seg = SEG_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (load && is_last) begin
        active <= 1'b0;
      end
      if (load) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      digits   <= q_head.digits;
      nonzero  <= q_head.nonzero;
      negative <= q_head.negative;
      pos      <= q_head.pos;
      d        <= 3'd0;
    end else if (load) begin
      if (minus_used) negative <= 1'b0;
      if (pos != POS_FLOOR) pos <= 4'(pos - 4'd1);
      d <= 3'(d + 3'd1);
    end
    if (load) begin
      dst_word.digit_index  <= d;
      dst_word.segments     <= seg;
      dst_word.digit_select <= 8'(8'd1 << d);
      dst_word.last_digit   <= is_last;
    end
  end

endmodule

@@ sim/tb_signed_decimal_to_seven_segment_frames.sv @@
// ----------------------------------------------------------------------------
// tb_signed_decimal_to_seven_segment_frames: self-checking frame word test
// feeds signed values with decimal point positions through the src channel,
// predicts the DIGITS frame words of every accepted request and checks each
// word taken from the dst channel in order, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_signed_decimal_to_seven_segment_frames;
  import sdss_pkg::*;

  localparam int DISPLAY_DIGITS = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_REQS    = 128;
  localparam int TAIL_CYCLES    = 60;
  localparam int RUN_LIMIT      = 800000;      // hang guard limit in simulation time

  // lit segments a..g for decimal digits 0..9
  localparam logic [7:0] DIGIT_LIT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // a request waiting to be sent; drain_first holds it back until every
  // frame word in flight has come out
  typedef struct {
    sdss_req_t req;
    bit        drain_first;
  } pending_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_stall;
  sdss_req_t  src_req = '0;
  logic       dst_valid;
  logic       dst_stall = 1'b0;
  sdss_word_t dst_word;

  pending_req_t pending_reqs_q[$];
  sdss_word_t   expected_words_q[$];
  sdss_word_t   exp_word;
  logic         src_taken = 1'b0;    // request accepted at the last rising edge

  int reqs_sent       = 0;
  int reqs_taken      = 0;
  int words_checked   = 0;
  int mismatch_count  = 0;
  int negative_frames = 0;
  int minus_frames    = 0;
  int point_frames    = 0;

  signed_decimal_to_seven_segment_frames #(
    .DIGITS(DISPLAY_DIGITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_req   (src_req),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // frame prediction: split the magnitude into decimal digits, least
  // significant first, with the point countdown and minus/blank handling
  // ---------------------------------------------------------------------------
  function automatic void predict_frame_words(input sdss_req_t r);
    logic [31:0] mag;
    logic [3:0]  digit;
    logic [7:0]  lit;
    logic        negative;
    int          pos;
    bit          point_seen;
    bit          minus_seen;
    sdss_word_t  w;
    negative   = r.value[31];
    // true magnitude, also for the most negative value
    mag        = negative ? (32'd0 - r.value) : r.value;
    pos        = int'($signed(r.point_position));
    point_seen = 1'b0;
    minus_seen = 1'b0;
    for (int d = 0; d < DISPLAY_DIGITS; d++) begin
      digit = 4'(mag % 32'd10);
      if (mag != 32'd0 || pos >= 0) begin
        // digit still shown: remaining value nonzero or point not passed yet
        lit = DIGIT_LIT[digit];
        if (pos == 0) begin
          lit        = lit | SEG_POINT;
          point_seen = 1'b1;
        end
        w.segments = ~lit;
      end else if (negative) begin
        // first blank position of a negative value carries the sign
        negative   = 1'b0;
        minus_seen = 1'b1;
        w.segments = SEG_MINUS;
      end else begin
        w.segments = SEG_BLANK;
      end
      w.digit_index  = 3'(d);
      w.digit_select = 8'(1 << d);
      w.last_digit   = (d == DISPLAY_DIGITS - 1);
      expected_words_q.push_back(w);
      mag = mag / 32'd10;
      // countdown saturates at -8
      if (pos > -8) begin
        pos--;
      end
    end
    if (r.value[31]) begin
      negative_frames++;
    end
    if (minus_seen) begin
      minus_frames++;
    end
    if (point_seen) begin
      point_frames++;
    end
  endfunction

  task automatic queue_req(input logic [31:0] value, input logic [3:0] pos,
                           input bit drain_first);
    pending_req_t p;
    p.req.value          = value;
    p.req.point_position = pos;
    p.drain_first        = drain_first;
    pending_reqs_q.push_back(p);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: changes at the falling edge, holds a request until it is
  // taken, idles about 30% of the time outside a steady stretch
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || src_taken) begin
      if (pending_reqs_q.size() != 0 &&
          !(pending_reqs_q[0].drain_first && expected_words_q.size() != 0) &&
          ((reqs_sent >= 60 && reqs_sent < 100) || $urandom_range(99) >= 30)) begin
        src_req   <= pending_reqs_q[0].req;
        src_valid <= 1'b1;
        void'(pending_reqs_q.pop_front());
        reqs_sent++;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, with a stretch of words taken without stalls
  always @(negedge clk) begin
    if (rst) begin
      dst_stall <= 1'b0;
    end else if (words_checked >= 400 && words_checked < 720) begin
      dst_stall <= 1'b0;
    end else begin
      dst_stall <= ($urandom_range(99) < 30);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted request, check every accepted word
  // against the oldest expectation, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      src_taken <= 1'b0;
    end else begin
      src_taken <= src_valid && !src_stall;
      if (src_valid && !src_stall) begin
        predict_frame_words(src_req);
        reqs_taken++;
      end
      if (dst_valid && !dst_stall) begin
        if (expected_words_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected frame word: index %0d seg %h sel %h last %b",
                     dst_word.digit_index, dst_word.segments,
                     dst_word.digit_select, dst_word.last_digit);
          end
        end else begin
          exp_word = expected_words_q.pop_front();
          words_checked++;
          if (dst_word.digit_index  !== exp_word.digit_index  ||
              dst_word.segments     !== exp_word.segments     ||
              dst_word.digit_select !== exp_word.digit_select ||
              dst_word.last_digit   !== exp_word.last_digit) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("word mismatch: expected index %0d seg %h sel %h last %b",
                       exp_word.digit_index, exp_word.segments,
                       exp_word.digit_select, exp_word.last_digit);
              $display("               got      index %0d seg %h sel %h last %b",
                       dst_word.digit_index, dst_word.segments,
                       dst_word.digit_select, dst_word.last_digit);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] mag;
    logic [31:0] value;
    int          kind;
    // directed: extremes, blanking, point countdown, sign placement
    queue_req(32'd0, 4'hF, 1'b0);                    // zero with blanking
    queue_req(32'd0, 4'h0, 1'b0);                    // zero with point on digit 0
    queue_req(32'h7FFF_FFFF, 4'hF, 1'b0);            // largest, top digits dropped
    queue_req(-32'sd2147483647, 4'hF, 1'b0);
    queue_req(32'h8000_0000, 4'hF, 1'b0);            // most negative value
    queue_req(32'h8000_0000, 4'h3, 1'b0);
    queue_req(-32'sd1, 4'hF, 1'b0);                  // minus right above one digit
    queue_req(-32'sd5, 4'h2, 1'b0);                  // leading zeros, then minus
    queue_req(32'd12345, 4'h7, 1'b0);                // point on the top digit
    queue_req(-32'sd12345678, 4'hF, 1'b0);           // no room left for the minus
    queue_req(-32'sd1234567, 4'hF, 1'b0);            // minus on the top digit
    queue_req(32'd99999999, 4'h7, 1'b0);
    queue_req(32'd100000000, 4'h0, 1'b0);            // ninth digit dropped
    queue_req(-32'sd42, 4'h8, 1'b0);                 // positions below -1 blank too
    queue_req(-32'sd42, 4'hE, 1'b0);
    queue_req(32'd42, 4'h9, 1'b0);
    queue_req(32'd0, 4'h7, 1'b0);                    // all zeros shown
    queue_req(-32'sd3, 4'h5, 1'b0);                  // point well above the value
    queue_req(32'd7, 4'h3, 1'b0);
    queue_req(-32'sd9876543, 4'h1, 1'b1);            // sent only once drained
    queue_req(32'd1000, 4'h6, 1'b0);
    queue_req(32'hFFFF_FFFF, 4'h4, 1'b0);
    // random: full-range values plus small and mid-size ones around the
    // point and sign corners; every position code equally likely
    for (int i = 0; i < RANDOM_REQS; i++) begin
      kind = $urandom_range(3);
      case (kind)
        0: value = $urandom;
        1: begin
          mag   = $urandom_range(999);
          value = $urandom_range(1) ? (32'd0 - mag) : mag;
        end
        2: begin
          mag   = $urandom_range(99999999);
          value = $urandom_range(1) ? (32'd0 - mag) : mag;
        end
        default: begin
          mag   = $urandom_range(9999999, 999999);
          value = $urandom_range(1) ? (32'd0 - mag) : mag;
        end
      endcase
      queue_req(value, 4'($urandom_range(15)), (i == 50 || i == 110));
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all requests out, all frame words back, then a quiet tail
    while (pending_reqs_q.size() != 0 || src_valid) begin
      @(posedge clk);
    end
    while (expected_words_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests: %0d taken, %0d negative, %0d showing a minus, %0d with a point",
             reqs_taken, negative_frames, minus_frames, point_frames);
    $display("frame words checked: %0d, mismatches: %0d", words_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("timeout: %0d frame words still expected", expected_words_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
